// ===== src/ordered_stack_engine_macros.svh =====
// ============================================================================
// ordered_stack_engine assertion macros
// Concurrent check wrappers; NO_ASSERTIONS compiles them out.
// ============================================================================
`ifndef ORDERED_STACK_ENGINE_MACROS_SVH
`define ORDERED_STACK_ENGINE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define OSE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered_stack_engine: same-cycle check failed");

// next-cycle implication
`define OSE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered_stack_engine: next-cycle check failed");

`else

`define OSE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OSE_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/ose_pkg.sv =====
// ============================================================================
// ose_pkg
// Shared sizes, codes and structs of the ordered stack engine.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ose_pkg;

    localparam int DEPTH = 64;
    localparam int AW    = $clog2(DEPTH);      // entry address
    localparam int CW    = $clog2(DEPTH + 1);  // fill level, 0..DEPTH

    localparam logic [2:0] OP_PUSH       = 3'd0;
    localparam logic [2:0] OP_POP        = 3'd1;
    localparam logic [2:0] OP_INSERT     = 3'd2;
    localparam logic [2:0] OP_REMOVE_ONE = 3'd3;
    localparam logic [2:0] OP_REMOVE_ALL = 3'd4;
    localparam logic [2:0] OP_CONTAINS   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic          idle;
        logic          done;
        logic [CW-1:0] fill;
    } t_eng_stat;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] popped;
        logic        found;
        logic [6:0]  removed;
        logic [6:0]  depth;
    } t_result;

endpackage

`default_nettype wire

// ===== src/ose_engine.sv =====
// ============================================================================
// ose_engine
// Entry memory, fill level and the sequencer around one shared comparator.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ose_engine (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [2:0]         i_op,
    input  wire logic [31:0]        i_val,
    input  wire logic               i_ack,
    output ose_pkg::t_eng_stat      o_stat,
    output ose_pkg::t_result        o_res
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_POP   = 8'b0000_0010,
        S_INS   = 8'b0000_0100,
        S_PUT   = 8'b0000_1000,
        S_FIND  = 8'b0001_0000,
        S_SHIFT = 8'b0010_0000,
        S_PACK  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state                     r_state, n_state;
    logic [2:0]                 r_op, n_op;
    logic [31:0]                r_val, n_val;
    logic [ose_pkg::CW-1:0]     r_fill, n_fill;
    logic [ose_pkg::AW-1:0]     r_ptr, n_ptr;
    logic [ose_pkg::CW-1:0]     r_wp, n_wp;
    logic [1:0]                 r_status, n_status;
    logic [31:0]                r_popped, n_popped;
    logic                       r_found, n_found;
    logic [ose_pkg::CW-1:0]     r_removed, n_removed;

    logic [31:0]                r_mem [ose_pkg::DEPTH];
    logic [31:0]                r_rdata;

    logic                       w_we;
    logic [ose_pkg::AW-1:0]     w_waddr;
    logic [31:0]                w_wdata;
    logic [ose_pkg::AW-1:0]     w_raddr;

    logic                       w_full, w_empty, w_ptr_last;
    logic [ose_pkg::AW-1:0]     w_last;
    logic                       w_eq, w_lt;

    // shared comparator: memory word against the operand
    assign w_eq = (r_rdata == r_val);
    assign w_lt = ($signed(r_rdata) < $signed(r_val));

    assign w_full     = (r_fill >= ose_pkg::CW'(ose_pkg::DEPTH));
    assign w_empty    = (r_fill == '0);
    assign w_last     = ose_pkg::AW'(r_fill - ose_pkg::CW'(1));
    assign w_ptr_last = (ose_pkg::CW'(r_ptr) == (r_fill - ose_pkg::CW'(1)));

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_val     = r_val;
        n_fill    = r_fill;
        n_ptr     = r_ptr;
        n_wp      = r_wp;
        n_status  = r_status;
        n_popped  = r_popped;
        n_found   = r_found;
        n_removed = r_removed;
        w_we      = 1'b0;
        w_waddr   = '0;
        w_wdata   = '0;
        w_raddr   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op      = i_op;
                    n_val     = i_val;
                    n_status  = ose_pkg::ST_OK;
                    n_popped  = '0;
                    n_found   = 1'b0;
                    n_removed = '0;
                    n_ptr     = '0;
                    n_wp      = '0;
                    n_state   = S_DONE;
                    unique case (i_op) inside
                        ose_pkg::OP_PUSH: begin
                            if (w_full) begin
                                n_status = ose_pkg::ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = ose_pkg::AW'(r_fill);
                                w_wdata = i_val;
                                n_fill  = r_fill + ose_pkg::CW'(1);
                            end
                        end
                        ose_pkg::OP_POP: begin
                            if (w_empty) begin
                                n_status = ose_pkg::ST_EMPTY;
                            end else begin
                                w_raddr = w_last;
                                n_fill  = r_fill - ose_pkg::CW'(1);
                                n_state = S_POP;
                            end
                        end
                        ose_pkg::OP_INSERT: begin
                            if (w_full) begin
                                n_status = ose_pkg::ST_FULL;
                            end else if (w_empty) begin
                                w_we    = 1'b1;
                                w_waddr = '0;
                                w_wdata = i_val;
                                n_fill  = ose_pkg::CW'(1);
                            end else begin
                                w_raddr = w_last;
                                n_ptr   = w_last;
                                n_state = S_INS;
                            end
                        end
                        ose_pkg::OP_REMOVE_ONE: begin
                            if (!w_empty) begin
                                w_raddr = w_last;
                                n_ptr   = w_last;
                                n_state = S_FIND;
                            end
                        end
                        ose_pkg::OP_REMOVE_ALL, ose_pkg::OP_CONTAINS: begin
                            if (!w_empty) begin
                                n_state = S_PACK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                n_popped  = r_rdata;
                n_removed = ose_pkg::CW'(1);
                n_state   = S_DONE;
            end
            S_INS: begin
                // smaller entries move up one slot while the walk goes down
                w_we    = 1'b1;
                w_waddr = r_ptr + ose_pkg::AW'(1);
                if (w_lt) begin
                    w_wdata = r_rdata;
                    if (r_ptr == '0) begin
                        n_state = S_PUT;
                    end else begin
                        n_ptr   = r_ptr - ose_pkg::AW'(1);
                        w_raddr = r_ptr - ose_pkg::AW'(1);
                    end
                end else begin
                    w_wdata = r_val;
                    n_fill  = r_fill + ose_pkg::CW'(1);
                    n_state = S_DONE;
                end
            end
            S_PUT: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = r_val;
                n_fill  = r_fill + ose_pkg::CW'(1);
                n_state = S_DONE;
            end
            S_FIND: begin
                if (w_eq) begin
                    n_found   = 1'b1;
                    n_removed = ose_pkg::CW'(1);
                    if (w_ptr_last) begin
                        n_fill  = r_fill - ose_pkg::CW'(1);
                        n_state = S_DONE;
                    end else begin
                        n_ptr   = r_ptr + ose_pkg::AW'(1);
                        w_raddr = r_ptr + ose_pkg::AW'(1);
                        n_state = S_SHIFT;
                    end
                end else if (r_ptr == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_ptr   = r_ptr - ose_pkg::AW'(1);
                    w_raddr = r_ptr - ose_pkg::AW'(1);
                end
            end
            S_SHIFT: begin
                // close the gap: entries above the match drop one slot
                w_we    = 1'b1;
                w_waddr = r_ptr - ose_pkg::AW'(1);
                w_wdata = r_rdata;
                if (w_ptr_last) begin
                    n_fill  = r_fill - ose_pkg::CW'(1);
                    n_state = S_DONE;
                end else begin
                    n_ptr   = r_ptr + ose_pkg::AW'(1);
                    w_raddr = r_ptr + ose_pkg::AW'(1);
                end
            end
            S_PACK: begin
                if (w_eq) begin
                    n_removed = r_removed + ose_pkg::CW'(1);
                end else if (r_op == ose_pkg::OP_REMOVE_ALL) begin
                    w_we    = 1'b1;
                    w_waddr = ose_pkg::AW'(r_wp);
                    w_wdata = r_rdata;
                    n_wp    = r_wp + ose_pkg::CW'(1);
                end
                if ((r_op == ose_pkg::OP_CONTAINS) && w_eq) begin
                    n_found   = 1'b1;
                    n_removed = '0;
                    n_state   = S_DONE;
                end else if (w_ptr_last) begin
                    if (r_op == ose_pkg::OP_REMOVE_ALL) begin
                        n_fill  = n_wp;
                        n_found = (n_removed != '0);
                    end else begin
                        n_removed = '0;
                    end
                    n_state = S_DONE;
                end else begin
                    n_ptr   = r_ptr + ose_pkg::AW'(1);
                    w_raddr = r_ptr + ose_pkg::AW'(1);
                end
            end
            S_DONE: begin
                if (i_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_val     <= n_val;
        r_ptr     <= n_ptr;
        r_wp      <= n_wp;
        r_status  <= n_status;
        r_popped  <= n_popped;
        r_found   <= n_found;
        r_removed <= n_removed;
    end

    // single write port, single registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = (r_state == S_DONE);
    assign o_stat.fill = r_fill;

    assign o_res.status  = r_status;
    assign o_res.popped  = r_popped;
    assign o_res.found   = r_found;
    assign o_res.removed = 7'(r_removed);
    assign o_res.depth   = 7'(r_fill);

endmodule

`default_nettype wire

// ===== src/ordered_stack_engine.sv =====
// ============================================================================
// ordered_stack_engine
// Bounded stack of signed 32-bit words with sorted insert and removals.
// ============================================================================
// One word in gives one word out. The slave side takes a word only while the
// engine is idle; each word then runs to completion before the next is taken.
// Sorted insert, remove first match, remove all and contains walk the stored
// entries through the single read port of the entry memory and the one
// comparator behind it: one entry is inspected per cycle. The result then
// moves into the output register, and the engine returns to idle, once the
// output slot is free; the register holds it until taken.
// A push or sorted insert on a full stack is rejected with status full; a
// pop on an empty stack is rejected with status empty. No clearing pass runs
// after reset: entries are read only below the fill level.
`timescale 1ns / 1ps
`default_nettype none

`include "ordered_stack_engine_macros.svh"

module ordered_stack_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [31:0] operand_value
    input  wire logic [2:0]  i_s_tuser,   // [2:0] opcode
    // master side
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [55:0]      o_m_tdata    // [1:0] status, [33:2] popped_value,
                                          // [34] match_found, [41:35] removed_count,
                                          // [48:42] stack_depth, [55:49] zero
);

    ose_pkg::t_eng_stat w_stat;
    ose_pkg::t_result   w_res;

    logic               w_s_acc;
    logic               w_ack;
    logic               r_m_tvalid;
    logic [55:0]        r_m_tdata;

    // engine idle doubles as input ready: one word in flight at a time
    assign o_s_tready = w_stat.idle;
    assign w_s_acc    = i_s_tvalid && o_s_tready;

    // output slot free, or being emptied this cycle
    assign w_ack = !r_m_tvalid || i_m_tready;

    ose_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_s_acc),
        .i_op    (i_s_tuser),
        .i_val   (i_s_tdata),
        .i_ack   (w_ack),
        .o_stat  (w_stat),
        .o_res   (w_res)
    );

    // output register: loads the finished result when the slot is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_stat.done && w_ack) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stat.done && w_ack) begin
            r_m_tdata <= {7'd0, w_res.depth, w_res.removed, w_res.found,
                          w_res.popped, w_res.status};
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    // ---------------------------------------------------------------- checks
    `OSE_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, w_s_acc, !w_stat.idle)
    `OSE_ASSERT_IMP(a_fill_bounded, i_clk, i_rst_n, 1'b1,
                    w_stat.fill <= ose_pkg::CW'(ose_pkg::DEPTH))
    `OSE_ASSERT_IMP(a_full_depth, i_clk, i_rst_n,
                    r_m_tvalid && (r_m_tdata[1:0] == ose_pkg::ST_FULL),
                    r_m_tdata[48:42] == 7'(ose_pkg::DEPTH))
    `OSE_ASSERT_IMP(a_empty_result, i_clk, i_rst_n,
                    r_m_tvalid && (r_m_tdata[1:0] == ose_pkg::ST_EMPTY),
                    (r_m_tdata[48:42] == 7'd0) && (r_m_tdata[33:2] == 32'd0))

endmodule

`default_nettype wire

// ===== verif/tb_ordered_stack_engine.sv =====
// ============================================================================
// tb_ordered_stack_engine
// Self-checking bench for the ordered stack engine: a behavioral stack model
// predicts every result word, which is checked field by field as it leaves.
// ============================================================================
`timescale 1ns / 1ps

module tb_ordered_stack_engine;

    // codes the engine treats as no operation
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    localparam int HOLD_OFF_CYCLES = 300;       // long receiver stall
    localparam int DRAIN_CYCLES    = 2 * ose_pkg::DEPTH + 8;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata  = '0;   // [31:0] operand_value
    logic [2:0]  i_s_tuser  = '0;   // [2:0] opcode
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [55:0] o_m_tdata;         // [1:0] status, [33:2] popped_value,
                                    // [34] match_found, [41:35] removed_count,
                                    // [48:42] stack_depth, [55:49] zero

    ordered_stack_engine DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Stack model: entry 0 is the base, model_fill entries are live.
    // ------------------------------------------------------------------------
    logic signed [31:0] model_words [ose_pkg::DEPTH];
    int                 model_fill = 0;

    ose_pkg::t_result pending_results [$];   // results owed by the engine, oldest first
    int               mismatch_count = 0;

    // idling controls, changed by the tests
    bit tx_gaps_on    = 1'b0;
    bit rx_stalls_on  = 1'b0;
    bit rx_hold_req   = 1'b0;

    function automatic ose_pkg::t_result predict_stack_op(input logic [2:0] op,
                                                          input logic signed [31:0] v);
        ose_pkg::t_result r;
        int      pos, k, w, hits;
        bit      hit;
        r = '0;
        case (op)
            ose_pkg::OP_PUSH: begin
                if (model_fill >= ose_pkg::DEPTH) begin
                    r.status = ose_pkg::ST_FULL;
                end else begin
                    model_words[model_fill] = v;
                    model_fill++;
                end
            end
            ose_pkg::OP_POP: begin
                if (model_fill == 0) begin
                    r.status = ose_pkg::ST_EMPTY;
                end else begin
                    model_fill--;
                    r.popped  = model_words[model_fill];
                    r.removed = 7'd1;
                end
            end
            ose_pkg::OP_INSERT: begin
                if (model_fill >= ose_pkg::DEPTH) begin
                    r.status = ose_pkg::ST_FULL;
                end else begin
                    // walk down past entries strictly smaller (signed)
                    pos = model_fill;
                    while (pos > 0 && model_words[pos-1] < v)
                        pos--;
                    for (k = model_fill; k > pos; k--)
                        model_words[k] = model_words[k-1];
                    model_words[pos] = v;
                    model_fill++;
                end
            end
            ose_pkg::OP_REMOVE_ONE: begin
                hit = 1'b0;
                k = model_fill - 1;
                while (k >= 0 && !hit) begin
                    if (model_words[k] == v) begin
                        for (w = k; w < model_fill - 1; w++)
                            model_words[w] = model_words[w+1];
                        model_fill--;
                        hit = 1'b1;
                    end
                    k--;
                end
                r.found   = hit;
                r.removed = hit ? 7'd1 : 7'd0;
            end
            ose_pkg::OP_REMOVE_ALL: begin
                w = 0;
                hits = 0;
                for (k = 0; k < model_fill; k++) begin
                    if (model_words[k] == v) begin
                        hits++;
                    end else begin
                        model_words[w] = model_words[k];
                        w++;
                    end
                end
                model_fill = w;
                r.removed  = hits[6:0];
                r.found    = (hits != 0);
            end
            ose_pkg::OP_CONTAINS: begin
                for (k = 0; k < model_fill; k++)
                    if (model_words[k] == v)
                        r.found = 1'b1;
            end
            default: ;
        endcase
        r.depth = model_fill[6:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: one word per call. Valid is left high after acceptance so that
    // back-to-back words never lower and raise it in the same step.
    // ------------------------------------------------------------------------
    task automatic issue_word(input logic [2:0] op, input logic [31:0] val);
        if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= val;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_results.push_back(predict_stack_op(op, val));
    endtask

    // sender goes quiet until every owed result has been taken
    task automatic pause_until_drained();
        if (pending_results.size() != 0) begin
            i_s_tvalid <= 1'b0;
            while (pending_results.size() != 0) @(posedge i_clk);
        end
    endtask

    // mostly a small pool so removals and contains find duplicates
    function automatic logic [31:0] pick_value(input bit from_stack);
        int sel;
        sel = $urandom_range(0, 9);
        if (from_stack && model_fill > 0 && sel < 4)
            return model_words[$urandom_range(0, model_fill - 1)];
        if (sel < 6)
            return 32'($signed($urandom_range(0, 8)) - 4);
        if (sel == 6) begin
            case ($urandom_range(0, 3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom();
    endfunction

    // grow favors push and insert, otherwise pops and removals dominate
    function automatic logic [2:0] pick_op(input bit grow);
        int r;
        r = $urandom_range(0, 99);
        if (grow) begin
            if (r < 30) return ose_pkg::OP_PUSH;
            if (r < 55) return ose_pkg::OP_INSERT;
            if (r < 65) return ose_pkg::OP_POP;
            if (r < 77) return ose_pkg::OP_REMOVE_ONE;
            if (r < 85) return ose_pkg::OP_REMOVE_ALL;
            if (r < 97) return ose_pkg::OP_CONTAINS;
        end else begin
            if (r < 10) return ose_pkg::OP_PUSH;
            if (r < 20) return ose_pkg::OP_INSERT;
            if (r < 55) return ose_pkg::OP_POP;
            if (r < 70) return ose_pkg::OP_REMOVE_ONE;
            if (r < 85) return ose_pkg::OP_REMOVE_ALL;
            if (r < 97) return ose_pkg::OP_CONTAINS;
        end
        return ($urandom_range(0, 1) != 0) ? OP_SPARE_A : OP_SPARE_B;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver ready: random stall bursts, or one long hold-off on request.
    // ------------------------------------------------------------------------
    initial begin : ready_driver
        int n;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                i_m_tready <= 1'b0;
                for (n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else if (rx_stalls_on && $urandom_range(0, 4) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatch_count++;
        $display("%0t ns: MISMATCH %s got 0x%0h want 0x%0h",
                 $realtime, what, got, want);
    endtask

    always @(posedge i_clk) begin : result_check
        ose_pkg::t_result want_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result word", o_m_tdata[31:0], '0);
            end else begin
                want_r = pending_results.pop_front();
                if (o_m_tdata[1:0] !== want_r.status)
                    note_mismatch("status", 32'(o_m_tdata[1:0]), 32'(want_r.status));
                if (o_m_tdata[33:2] !== want_r.popped)
                    note_mismatch("popped_value", o_m_tdata[33:2], want_r.popped);
                if (o_m_tdata[34] !== want_r.found)
                    note_mismatch("match_found", 32'(o_m_tdata[34]), 32'(want_r.found));
                if (o_m_tdata[41:35] !== want_r.removed)
                    note_mismatch("removed_count", 32'(o_m_tdata[41:35]),
                                  32'(want_r.removed));
                if (o_m_tdata[48:42] !== want_r.depth)
                    note_mismatch("stack_depth", 32'(o_m_tdata[48:42]),
                                  32'(want_r.depth));
                if (o_m_tdata[55:49] !== 7'd0)
                    note_mismatch("pad bits", 32'(o_m_tdata[55:49]), '0);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // value extremes through push and pop, then pop on an empty stack
    task automatic test_push_pop_extremes();
        issue_word(ose_pkg::OP_PUSH, 32'h7FFF_FFFF);
        issue_word(ose_pkg::OP_PUSH, 32'h8000_0000);
        issue_word(ose_pkg::OP_PUSH, 32'h0000_0000);
        issue_word(ose_pkg::OP_PUSH, 32'hFFFF_FFFF);
        repeat (4) issue_word(ose_pkg::OP_POP, 32'h0000_0000);
        issue_word(ose_pkg::OP_POP, 32'hA5A5_5A5A);
    endtask

    // removals and membership with nothing stored, a spare code when empty
    task automatic test_empty_queries();
        issue_word(ose_pkg::OP_REMOVE_ONE, 32'h0000_0000);
        issue_word(ose_pkg::OP_REMOVE_ALL, 32'hFFFF_FFFF);
        issue_word(ose_pkg::OP_CONTAINS, 32'h8000_0000);
        issue_word(OP_SPARE_A, 32'h1234_5678);
    endtask

    // sorted insert across the sign boundary, with ties
    task automatic test_sorted_insert();
        issue_word(ose_pkg::OP_INSERT, 32'd5);
        issue_word(ose_pkg::OP_INSERT, -32'sd3);
        issue_word(ose_pkg::OP_INSERT, 32'd5);
        issue_word(ose_pkg::OP_INSERT, 32'h7FFF_FFFF);
        issue_word(ose_pkg::OP_INSERT, 32'h8000_0000);
        issue_word(ose_pkg::OP_PUSH, 32'd5);
    endtask

    // matches, misses and close-the-gap removals on the stack left above
    task automatic test_removals();
        issue_word(ose_pkg::OP_CONTAINS, 32'd4);
        issue_word(ose_pkg::OP_CONTAINS, 32'h8000_0000);
        issue_word(ose_pkg::OP_REMOVE_ONE, 32'd5);
        issue_word(ose_pkg::OP_REMOVE_ONE, 32'd6);
        issue_word(OP_SPARE_B, 32'hFFFF_FFFF);
        issue_word(ose_pkg::OP_REMOVE_ALL, 32'd5);
        issue_word(ose_pkg::OP_REMOVE_ALL, 32'h7FFF_FFFF);
        issue_word(ose_pkg::OP_POP, 32'h0000_0000);
        issue_word(ose_pkg::OP_POP, 32'h0000_0000);
        pause_until_drained();
    endtask

    // random content up to capacity, both rejections when full, then drain
    task automatic test_fill_to_capacity();
        while (model_fill < ose_pkg::DEPTH)
            issue_word(($urandom_range(0, 1) != 0) ? ose_pkg::OP_PUSH : ose_pkg::OP_INSERT,
                       pick_value(1'b0));
        issue_word(ose_pkg::OP_PUSH, $urandom());
        issue_word(ose_pkg::OP_INSERT, 32'h8000_0000);
        issue_word(ose_pkg::OP_CONTAINS, pick_value(1'b1));
        while (model_fill > 0)
            issue_word(ose_pkg::OP_POP, $urandom());
        issue_word(ose_pkg::OP_POP, $urandom());
        pause_until_drained();
    endtask

    // receiver stops for a long stretch while the sender keeps offering words
    task automatic test_output_backpressure();
        rx_hold_req = 1'b1;
        repeat (24) issue_word(pick_op(1'b1), pick_value(1'b1));
        pause_until_drained();
    endtask

    // segments of random traffic; the stack alternately grows and shrinks,
    // idling varies per segment and is off for the closing segments
    task automatic test_random_mix();
        int seg;
        bit grow;
        for (seg = 0; seg < 10; seg++) begin
            grow = (seg % 2 == 0);
            if (seg < 8) begin
                tx_gaps_on   = $urandom_range(0, 2) != 0;
                rx_stalls_on = $urandom_range(0, 2) != 0;
            end else begin
                tx_gaps_on   = 1'b0;
                rx_stalls_on = 1'b0;
            end
            repeat (47) issue_word(pick_op(grow), pick_value(1'b1));
            if ($urandom_range(0, 2) == 0)
                pause_until_drained();
        end
        pause_until_drained();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_push_pop_extremes();
        test_empty_queries();
        test_sorted_insert();
        test_removals();

        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        test_fill_to_capacity();
        test_output_backpressure();
        test_random_mix();

        // catch any stray word after the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/ose_pkg.sv
src/ose_engine.sv
src/ordered_stack_engine.sv
verif/tb_ordered_stack_engine.sv
